[rtl/som_pkg.sv]
// Shared constants and codes for the color self-organizing map block.
`timescale 1ns / 1ps
package som_pkg;

   // Default sizing
   localparam int MAX_GRID_DEFAULT  = 16;
   localparam int EXP_DEPTH_DEFAULT = 256;

   // Item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_TRAIN = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // Config register indexes
   localparam int          CSR_IDX_W        = 3;
   localparam int          CSR_DATA_W       = 32;
   localparam logic [2:0]  CSR_GRID_MODE    = 3'd0;
   localparam logic [2:0]  CSR_GRID_SIZE    = 3'd1;
   localparam logic [2:0]  CSR_LEARN_RATE   = 3'd2;
   localparam logic [2:0]  CSR_INIT_RADIUS  = 3'd3;
   localparam logic [2:0]  CSR_DECAY_INV    = 3'd4;

   // Fixed-point layout
   localparam int COMP_W     = 16;            // Q0.16 weight component
   localparam int WORD_W     = 3 * COMP_W;    // packed node weight
   localparam int EXP_W      = 17;            // Q1.16 exp, up to 1.0
   localparam int EXP_ARG_LO = 16;            // decay product to Q.16
   localparam int EXP_LIM    = 19;            // exp argument range is [0, 8) in Q.16
   localparam int SIGMA_W    = 24;            // Q8.16 radius
   localparam int S2_W       = 48;            // Q16.32 radius squared
   localparam int GAUSS_SH   = 47;            // d2 alignment for the Gaussian argument
   localparam int QUOT_W     = 19;            // Gaussian argument bits kept
   localparam int REM_W      = S2_W + QUOT_W; // divider datapath

endpackage

[rtl/som_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module som_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/som_div.sv]
// Restoring divider for the Gaussian argument, one quotient bit per cycle.
`timescale 1ns / 1ps
module som_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [som_pkg::REM_W-1:0]  numer,
   input  logic [som_pkg::S2_W-1:0]   denom,
   output logic [som_pkg::QUOT_W-1:0] quot,
   output logic                       done
);
   import som_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsr_ff, dsr_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              fits;

   // quotient is known to be below 2^QUOT_W, so start with divisor aligned at the top bit
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      fits    = rem_ff >= dsr_ff;
      if (start) begin
         rem_in  = numer;
         dsr_in  = REM_W'(denom) << (QUOT_W - 1);
         quot_in = '0;
         cnt_in  = CNT_W'(QUOT_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsr_ff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsr_in  = dsr_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

[rtl/som_dist.sv]
// Pipelined nearest-node search: squared color distance and running first minimum.
`timescale 1ns / 1ps
module som_dist #(
   parameter int AW = 8,
   parameter int CW = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       in_valid,
   input  logic [som_pkg::WORD_W-1:0] weight,
   input  logic [som_pkg::COMP_W-1:0] samp_r,
   input  logic [som_pkg::COMP_W-1:0] samp_g,
   input  logic [som_pkg::COMP_W-1:0] samp_b,
   input  logic [AW-1:0]              in_idx,
   input  logic [CW-1:0]              in_row,
   input  logic [CW-1:0]              in_col,
   output logic                       busy,
   output logic [AW-1:0]              best_idx,
   output logic [CW-1:0]              best_row,
   output logic [CW-1:0]              best_col
);
   import som_pkg::*;

   localparam int SQ_W  = 2 * COMP_W;
   localparam int SUM_W = SQ_W + 2;

   logic              s1_v_ff;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [AW-1:0]     s1_idx_ff;
   logic [CW-1:0]     s1_row_ff, s1_col_ff;
   logic [SUM_W-1:0]  best_d_ff;
   logic              have_ff;
   logic [AW-1:0]     best_idx_ff;
   logic [CW-1:0]     best_row_ff, best_col_ff;
   logic [COMP_W-1:0] ad_r, ad_g, ad_b;
   logic [SUM_W-1:0]  sum;

   always_comb begin
      ad_r = (samp_r >= weight[3*COMP_W-1:2*COMP_W]) ?
             samp_r - weight[3*COMP_W-1:2*COMP_W] : weight[3*COMP_W-1:2*COMP_W] - samp_r;
      ad_g = (samp_g >= weight[2*COMP_W-1:COMP_W]) ?
             samp_g - weight[2*COMP_W-1:COMP_W] : weight[2*COMP_W-1:COMP_W] - samp_g;
      ad_b = (samp_b >= weight[COMP_W-1:0]) ?
             samp_b - weight[COMP_W-1:0] : weight[COMP_W-1:0] - samp_b;
      sum  = SUM_W'(sq_r_ff) + SUM_W'(sq_g_ff) + SUM_W'(sq_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
         if (clear) begin
            have_ff <= 1'b0;
         end else if (s1_v_ff) begin
            have_ff <= 1'b1;
         end
      end
      sq_r_ff   <= SQ_W'(ad_r) * SQ_W'(ad_r);
      sq_g_ff   <= SQ_W'(ad_g) * SQ_W'(ad_g);
      sq_b_ff   <= SQ_W'(ad_b) * SQ_W'(ad_b);
      s1_idx_ff <= in_idx;
      s1_row_ff <= in_row;
      s1_col_ff <= in_col;
      // strict less-than keeps the first minimum
      if (s1_v_ff && (!have_ff || sum < best_d_ff)) begin
         best_d_ff   <= sum;
         best_idx_ff <= s1_idx_ff;
         best_row_ff <= s1_row_ff;
         best_col_ff <= s1_col_ff;
      end
   end

   assign busy     = s1_v_ff;
   assign best_idx = best_idx_ff;
   assign best_row = best_row_ff;
   assign best_col = best_col_ff;

endmodule

[rtl/som_color_training_step.sv]
// Top level of the color self-organizing map: node store, sequencer and update datapath.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; every item of kind load, train
// or read yields one result word, shown on the rsp_ ports for a single cycle with
// rsp_valid high. The receiver cannot stall, so capture it then. A load answers in the
// cycle after it is taken; a read first passes through the READ state. A train item runs
// through the node memory twice over its single read port: a search pass over the N nodes
// in use (SCAN, then DRAIN), decay setup in DEC, AEXP, LRSG and S2, then per node NODE,
// THETA, FACT, MUL and WR when its Gaussian is nonzero and NODE, THETA and WR (or DONE)
// when it is zero, with the bit-serial divider (DIV, TAB) between THETA and FACT for every
// node other than the winner that lies within four radii; the DONE state forms the result.
// A zero rate after decay skips the update pass. Kind 3 gives no result. Node weights are
// undefined until loaded; config writes only while idle.
module som_color_training_step #(
   parameter int MAX_GRID        = som_pkg::MAX_GRID_DEFAULT,
   parameter int EXP_TABLE_DEPTH = som_pkg::EXP_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic [7:0]                    req_node_index,
   input  logic [som_pkg::COMP_W-1:0]    req_red_in,
   input  logic [som_pkg::COMP_W-1:0]    req_green_in,
   input  logic [som_pkg::COMP_W-1:0]    req_blue_in,
   input  logic [15:0]                   req_step_index,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_winner_index,
   output logic [23:0]                   rsp_pixel_rgb,
   output logic [1:0]                    rsp_ack_kind,
   input  logic                          csr_write,
   input  logic [som_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [som_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import som_pkg::*;

   localparam int NODES = MAX_GRID * MAX_GRID;
   localparam int AW    = $clog2(NODES);
   localparam int CW    = $clog2(MAX_GRID);
   localparam int GSW   = CW + 1;
   localparam int CNTW  = AW + 1;
   localparam int D2W   = 2 * CW + 1;
   localparam int TW    = $clog2(EXP_TABLE_DEPTH);
   localparam logic [63:0] EXP_STEP = (64'd8 << 32) / EXP_TABLE_DEPTH;

   // Taylor terms of exp(-8/depth) in Q0.32, each step truncating
   localparam logic [127:0] EXP_T0  = 128'd1 << 32;
   localparam logic [127:0] EXP_T1  = (EXP_T0 * 128'(EXP_STEP)) >> 32;
   localparam logic [127:0] EXP_T2  = ((EXP_T1 * 128'(EXP_STEP)) >> 32) / 2;
   localparam logic [127:0] EXP_T3  = ((EXP_T2 * 128'(EXP_STEP)) >> 32) / 3;
   localparam logic [127:0] EXP_T4  = ((EXP_T3 * 128'(EXP_STEP)) >> 32) / 4;
   localparam logic [127:0] EXP_T5  = ((EXP_T4 * 128'(EXP_STEP)) >> 32) / 5;
   localparam logic [127:0] EXP_T6  = ((EXP_T5 * 128'(EXP_STEP)) >> 32) / 6;
   localparam logic [127:0] EXP_T7  = ((EXP_T6 * 128'(EXP_STEP)) >> 32) / 7;
   localparam logic [127:0] EXP_T8  = ((EXP_T7 * 128'(EXP_STEP)) >> 32) / 8;
   localparam logic [127:0] EXP_T9  = ((EXP_T8 * 128'(EXP_STEP)) >> 32) / 9;
   localparam logic [127:0] EXP_T10 = ((EXP_T9 * 128'(EXP_STEP)) >> 32) / 10;
   localparam logic [127:0] EXP_T11 = ((EXP_T10 * 128'(EXP_STEP)) >> 32) / 11;
   localparam logic [127:0] EXP_T12 = ((EXP_T11 * 128'(EXP_STEP)) >> 32) / 12;
   localparam logic [127:0] EXP_T13 = ((EXP_T12 * 128'(EXP_STEP)) >> 32) / 13;
   localparam logic [127:0] EXP_T14 = ((EXP_T13 * 128'(EXP_STEP)) >> 32) / 14;
   localparam logic [127:0] EXP_T15 = ((EXP_T14 * 128'(EXP_STEP)) >> 32) / 15;
   localparam logic [127:0] EXP_T16 = ((EXP_T15 * 128'(EXP_STEP)) >> 32) / 16;
   localparam logic [127:0] EXP_POS = EXP_T0 + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8
                                      + EXP_T10 + EXP_T12 + EXP_T14 + EXP_T16;
   localparam logic [127:0] EXP_NEG = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9
                                      + EXP_T11 + EXP_T13 + EXP_T15;
   localparam logic [127:0] EXP_RDIFF = (EXP_POS > EXP_NEG) ? EXP_POS - EXP_NEG : '0;
   localparam logic [127:0] EXP_RATIO = (EXP_RDIFF > 128'h0FFFF_FFFF) ? 128'h0FFFF_FFFF
                                                                      : EXP_RDIFF;

   // exp(-8k/depth) table in Q1.16, built at elaboration by the integer recurrence
   typedef logic [EXP_W-1:0] exp_tab_type [EXP_TABLE_DEPTH];

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type  tab;
      logic [127:0] v;
      v = 128'd1 << 32;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         tab[k] = EXP_W'((v + 128'd32768) >> 16);
         v = (v * EXP_RATIO) >> 32;
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

   typedef enum logic [15:0] {
      ST_IDLE  = 16'b0000_0000_0000_0001,
      ST_READ  = 16'b0000_0000_0000_0010,
      ST_SCAN  = 16'b0000_0000_0000_0100,
      ST_DRAIN = 16'b0000_0000_0000_1000,
      ST_DEC   = 16'b0000_0000_0001_0000,
      ST_AEXP  = 16'b0000_0000_0010_0000,
      ST_LRSG  = 16'b0000_0000_0100_0000,
      ST_S2    = 16'b0000_0000_1000_0000,
      ST_NODE  = 16'b0000_0001_0000_0000,
      ST_THETA = 16'b0000_0010_0000_0000,
      ST_DIV   = 16'b0000_0100_0000_0000,
      ST_TAB   = 16'b0000_1000_0000_0000,
      ST_FACT  = 16'b0001_0000_0000_0000,
      ST_MUL   = 16'b0010_0000_0000_0000,
      ST_WR    = 16'b0100_0000_0000_0000,
      ST_DONE  = 16'b1000_0000_0000_0000
   } state_type;

   // config registers
   logic              grid_mode_ff;
   logic [4:0]        grid_size_ff;
   logic [15:0]       learn_rate_ff;
   logic [15:0]       init_radius_ff;
   logic [31:0]       decay_inv_ff;

   // sequencer and item state
   state_type         state_ff, state_in;
   logic              oob_ff, oob_in;
   logic [COMP_W-1:0] sr_ff, sr_in, sg_ff, sg_in, sb_ff, sb_in;
   logic [15:0]       step_ff, step_in;
   logic              mode_ff, mode_in;
   logic [GSW-1:0]    gs_ff, gs_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [AW-1:0]     node_ff, node_in;
   logic [CW-1:0]     row_ff, row_in, col_ff, col_in;
   logic              iss_v_ff;
   logic [AW-1:0]     iss_idx_ff;
   logic [CW-1:0]     iss_row_ff, iss_col_ff;

   // decay and update datapath
   logic [47:0]        dec_ff, dec_in;
   logic [EXP_W-1:0]   a_ff, a_in;
   logic [15:0]        lr_ff, lr_in;
   logic [SIGMA_W-1:0] sigma_ff, sigma_in;
   logic [S2_W-1:0]    s2_ff, s2_in;
   logic [D2W-1:0]     d2_ff, d2_in;
   logic [EXP_W-1:0]   theta_ff, theta_in;
   logic [15:0]        factor_ff, factor_in;
   logic [WORD_W-1:0]  wold_ff, wold_in;
   logic [2:0]         up_ff, up_in;
   logic [COMP_W-1:0]  del_r_ff, del_r_in, del_g_ff, del_g_in, del_b_ff, del_b_in;

   // result word
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_win_ff, rsp_win_in;
   logic [23:0]       rsp_px_ff, rsp_px_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;

   // memory, search and divider hookups
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;
   logic              search_clear, search_busy;
   logic [AW-1:0]     best_idx;
   logic [CW-1:0]     best_row, best_col;
   logic              div_start, div_done;
   logic [QUOT_W-1:0] div_quot;

   // helpers
   logic              accept;
   logic [GSW-1:0]    gs_clamped;
   logic              last_node;
   logic [CW-1:0]     dr, dc;
   logic [31:0]       tab_scaled_a, tab_scaled_q;
   logic [32:0]       lr_prod, sigma_prod, fact_prod;
   logic [COMP_W-1:0] w_r, w_g, w_b, df_r, df_g, df_b;
   logic [31:0]       pr_r, pr_g, pr_b;
   logic [23:0]       px_r, px_g, px_b;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   som_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NODES)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   som_dist #(
      .AW (AW),
      .CW (CW)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .clear    (search_clear),
      .in_valid (iss_v_ff),
      .weight   (ram_rdata),
      .samp_r   (sr_ff),
      .samp_g   (sg_ff),
      .samp_b   (sb_ff),
      .in_idx   (iss_idx_ff),
      .in_row   (iss_row_ff),
      .in_col   (iss_col_ff),
      .busy     (search_busy),
      .best_idx (best_idx),
      .best_row (best_row),
      .best_col (best_col)
   );

   som_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (REM_W'(d2_ff) << GAUSS_SH),
      .denom (s2_ff),
      .quot  (div_quot),
      .done  (div_done)
   );

   // grid size in use: zero acts as one, oversize clamps to the grid
   always_comb begin
      if (grid_size_ff == '0) begin
         gs_clamped = GSW'(1);
      end else if (32'(grid_size_ff) > MAX_GRID) begin
         gs_clamped = GSW'(MAX_GRID);
      end else begin
         gs_clamped = GSW'(grid_size_ff);
      end
   end

   assign last_node    = (CNTW'(node_ff) == count_ff - 1'b1);
   assign dr           = (row_ff > best_row) ? row_ff - best_row : best_row - row_ff;
   assign dc           = (col_ff > best_col) ? col_ff - best_col : best_col - col_ff;
   assign tab_scaled_a = 32'(dec_ff[EXP_ARG_LO+EXP_LIM-1:EXP_ARG_LO]) * 32'(EXP_TABLE_DEPTH);
   assign tab_scaled_q = 32'(div_quot) * 32'(EXP_TABLE_DEPTH);
   assign lr_prod      = 33'(learn_rate_ff) * 33'(a_ff);
   assign sigma_prod   = 33'(init_radius_ff) * 33'(a_ff);
   assign fact_prod    = 33'(lr_ff) * 33'(theta_ff);

   // per-component move toward the sample, magnitude and direction
   assign w_r  = ram_rdata[3*COMP_W-1:2*COMP_W];
   assign w_g  = ram_rdata[2*COMP_W-1:COMP_W];
   assign w_b  = ram_rdata[COMP_W-1:0];
   assign df_r = (sr_ff >= w_r) ? sr_ff - w_r : w_r - sr_ff;
   assign df_g = (sg_ff >= w_g) ? sg_ff - w_g : w_g - sg_ff;
   assign df_b = (sb_ff >= w_b) ? sb_ff - w_b : w_b - sb_ff;
   assign pr_r = 32'(factor_ff) * 32'(df_r);
   assign pr_g = 32'(factor_ff) * 32'(df_g);
   assign pr_b = 32'(factor_ff) * 32'(df_b);

   // pixel: component * 255 >> 16
   assign px_r = 24'(w_r) * 24'd255;
   assign px_g = 24'(w_g) * 24'd255;
   assign px_b = 24'(w_b) * 24'd255;

   always_comb begin
      state_in     = state_ff;
      oob_in       = oob_ff;
      sr_in        = sr_ff;
      sg_in        = sg_ff;
      sb_in        = sb_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      gs_in        = gs_ff;
      count_in     = count_ff;
      node_in      = node_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      dec_in       = dec_ff;
      a_in         = a_ff;
      lr_in        = lr_ff;
      sigma_in     = sigma_ff;
      s2_in        = s2_ff;
      d2_in        = d2_ff;
      theta_in     = theta_ff;
      factor_in    = factor_ff;
      wold_in      = wold_ff;
      up_in        = up_ff;
      del_r_in     = del_r_ff;
      del_g_in     = del_g_ff;
      del_b_in     = del_b_ff;
      rsp_valid_in = 1'b0;
      rsp_win_in   = rsp_win_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_kind_in  = rsp_kind_ff;
      ram_we       = 1'b0;
      ram_waddr    = node_ff;
      ram_wdata    = {req_red_in, req_green_in, req_blue_in};
      ram_raddr    = node_ff;
      search_clear = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            ram_raddr = AW'(req_node_index);
            if (accept) begin
               oob_in  = (32'(req_node_index) >= NODES);
               sr_in   = req_red_in;
               sg_in   = req_green_in;
               sb_in   = req_blue_in;
               step_in = req_step_index;
               case (req_kind)
                  KIND_LOAD: begin
                     ram_we       = (32'(req_node_index) < NODES);
                     ram_waddr    = AW'(req_node_index);
                     rsp_valid_in = 1'b1;
                     rsp_win_in   = '0;
                     rsp_px_in    = '0;
                     rsp_kind_in  = KIND_LOAD;
                  end
                  KIND_READ: begin
                     state_in = ST_READ;
                  end
                  KIND_TRAIN: begin
                     mode_in      = grid_mode_ff;
                     gs_in        = gs_clamped;
                     count_in     = grid_mode_ff ? CNTW'(gs_clamped) * CNTW'(gs_clamped)
                                                 : CNTW'(gs_clamped);
                     node_in      = '0;
                     row_in       = '0;
                     col_in       = '0;
                     search_clear = 1'b1;
                     state_in     = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_win_in   = '0;
            rsp_kind_in  = KIND_READ;
            rsp_px_in    = oob_ff ? '0 : {px_r[23:16], px_g[23:16], px_b[23:16]};
            state_in     = ST_IDLE;
         end

         ST_SCAN: begin
            // one node read per cycle into the distance pipeline
            if (last_node) begin
               state_in = ST_DRAIN;
            end
         end

         ST_DRAIN: begin
            if (!iss_v_ff && !search_busy) begin
               state_in = ST_DEC;
            end
         end

         ST_DEC: begin
            dec_in   = 48'(step_ff) * 48'(decay_inv_ff);
            state_in = ST_AEXP;
         end

         ST_AEXP: begin
            // argument at or past 8.0 gives zero
            if (dec_ff[47:EXP_ARG_LO+EXP_LIM] != '0) begin
               a_in = '0;
            end else begin
               a_in = EXP_TAB[tab_scaled_a[TW+EXP_LIM-1:EXP_LIM]];
            end
            state_in = ST_LRSG;
         end

         ST_LRSG: begin
            lr_in    = lr_prod[31:16];
            sigma_in = sigma_prod[SIGMA_W+7:8];
            state_in = ST_S2;
         end

         ST_S2: begin
            s2_in   = S2_W'(sigma_ff) * S2_W'(sigma_ff);
            node_in = '0;
            row_in  = '0;
            col_in  = '0;
            // zero rate: nothing moves
            state_in = (lr_ff == '0) ? ST_DONE : ST_NODE;
         end

         ST_NODE: begin
            d2_in    = D2W'(dr) * D2W'(dr) + D2W'(dc) * D2W'(dc);
            state_in = ST_THETA;
         end

         ST_THETA: begin
            if (d2_ff == '0) begin
               theta_in = EXP_W'(1) << 16;
               state_in = ST_FACT;
            end else if (s2_ff == '0 || ((64'(d2_ff) << (GAUSS_SH - EXP_LIM)) >= 64'(s2_ff))) begin
               // zero radius, or argument past the table: theta is zero
               state_in = last_node ? ST_DONE : ST_WR;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               state_in = ST_TAB;
            end
         end

         ST_TAB: begin
            theta_in = EXP_TAB[tab_scaled_q[TW+EXP_LIM-1:EXP_LIM]];
            state_in = ST_FACT;
         end

         ST_FACT: begin
            factor_in = fact_prod[31:16];
            state_in  = ST_MUL;
         end

         ST_MUL: begin
            wold_in  = ram_rdata;
            up_in    = {sr_ff >= w_r, sg_ff >= w_g, sb_ff >= w_b};
            del_r_in = pr_r[31:16];
            del_g_in = pr_g[31:16];
            del_b_in = pr_b[31:16];
            if (factor_ff == '0) begin
               up_in    = 3'b111;
               del_r_in = '0;
               del_g_in = '0;
               del_b_in = '0;
            end
            state_in = ST_WR;
         end

         ST_WR: begin
            // write back only when a nonzero factor was formed for this node
            if (factor_ff != '0 && theta_ff != '0) begin
               ram_we    = 1'b1;
               ram_wdata = {
                  up_ff[2] ? wold_ff[3*COMP_W-1:2*COMP_W] + del_r_ff
                           : wold_ff[3*COMP_W-1:2*COMP_W] - del_r_ff,
                  up_ff[1] ? wold_ff[2*COMP_W-1:COMP_W] + del_g_ff
                           : wold_ff[2*COMP_W-1:COMP_W] - del_g_ff,
                  up_ff[0] ? wold_ff[COMP_W-1:0] + del_b_ff
                           : wold_ff[COMP_W-1:0] - del_b_ff};
            end
            theta_in = '0;
            state_in = last_node ? ST_DONE : ST_NODE;
         end

         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_win_in   = 8'(best_idx);
            rsp_px_in    = '0;
            rsp_kind_in  = KIND_TRAIN;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // node walk, row-major; in 1D mode the column stays zero and every step advances the row
      if ((state_ff == ST_SCAN) || (state_ff == ST_WR && !last_node)) begin
         node_in = node_ff + 1'b1;
         if (mode_ff && (GSW'(col_ff) + 1'b1 < gs_ff)) begin
            col_in = col_ff + 1'b1;
         end else begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         iss_v_ff       <= 1'b0;
         grid_mode_ff   <= 1'b1;
         grid_size_ff   <= 5'd16;
         learn_rate_ff  <= 16'd10486;
         init_radius_ff <= 16'd1229;
         decay_inv_ff   <= 32'd1747626;
         theta_ff       <= '0;
         factor_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_v_ff     <= (state_ff == ST_SCAN);
         theta_ff     <= theta_in;
         factor_ff    <= factor_in;
         if (csr_write) begin
            case (csr_index)
               CSR_GRID_MODE:   grid_mode_ff   <= csr_wdata[0];
               CSR_GRID_SIZE:   grid_size_ff   <= csr_wdata[4:0];
               CSR_LEARN_RATE:  learn_rate_ff  <= csr_wdata[15:0];
               CSR_INIT_RADIUS: init_radius_ff <= csr_wdata[15:0];
               CSR_DECAY_INV:   decay_inv_ff   <= csr_wdata[31:0];
               default: begin
               end
            endcase
         end
      end
      oob_ff      <= oob_in;
      sr_ff       <= sr_in;
      sg_ff       <= sg_in;
      sb_ff       <= sb_in;
      step_ff     <= step_in;
      mode_ff     <= mode_in;
      gs_ff       <= gs_in;
      count_ff    <= count_in;
      node_ff     <= node_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      iss_idx_ff  <= node_ff;
      iss_row_ff  <= row_ff;
      iss_col_ff  <= col_ff;
      dec_ff      <= dec_in;
      a_ff        <= a_in;
      lr_ff       <= lr_in;
      sigma_ff    <= sigma_in;
      s2_ff       <= s2_in;
      d2_ff       <= d2_in;
      wold_ff     <= wold_in;
      up_ff       <= up_in;
      del_r_ff    <= del_r_in;
      del_g_ff    <= del_g_in;
      del_b_ff    <= del_b_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_px_ff   <= rsp_px_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_winner_index = rsp_win_ff;
   assign rsp_pixel_rgb    = rsp_px_ff;
   assign rsp_ack_kind     = rsp_kind_ff;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the color self-organizing map training block.
`timescale 1ns / 1ps
module testbench;
   import som_pkg::*;

   localparam int NODES      = 256;
   localparam int GRID_LIMIT = 16;
   localparam int TAB_DEPTH  = 256;
   localparam int STALL_MAX  = 200000;  // cycles without any handshake before giving up
   localparam int SETTLE     = 24;      // idle cycles before a register write / at the end
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_LOAD;
   logic [7:0]  req_node_index = '0;
   logic [15:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic [15:0] req_step_index = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_winner_index;
   logic [23:0] rsp_pixel_rgb;
   logic [1:0]  rsp_ack_kind;
   logic        csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   som_color_training_step DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_node_index(req_node_index),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .req_step_index(req_step_index),
      .rsp_valid(rsp_valid), .rsp_winner_index(rsp_winner_index),
      .rsp_pixel_rgb(rsp_pixel_rgb), .rsp_ack_kind(rsp_ack_kind),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // One expected result word
   typedef struct packed {
      logic [7:0]  winner;
      logic [23:0] pixel;
      logic [1:0]  kind;
   } som_word_type;

   som_word_type pending_words[$];
   int        errors = 0;
   int        quiet_cycles = 0;
   int        item_count = 0;
   bit        no_gaps = 1'b0;

   // Shadow map: weights and register copies
   bit [15:0] map_r[NODES], map_g[NODES], map_b[NODES];
   bit [31:0] exp_lut[TAB_DEPTH];
   bit        sh_mode = 1'b1;
   bit [4:0]  sh_size = 5'd16;
   bit [15:0] sh_rate = 16'd10486;
   bit [15:0] sh_radius = 16'd1229;
   bit [31:0] sh_decay = 32'd1747626;

   // exp(-8k/depth) table: Taylor series for the ratio, then repeated products
   task automatic build_exp_lut();
      longint unsigned d, term, pos, neg, r, v;
      d = (64'd8 << 32) / TAB_DEPTH;
      term = 64'd1 << 32;
      pos = term;
      neg = 0;
      for (int n = 1; n <= 16; n++) begin
         term = ((term * d) >> 32) / n;
         if (n % 2 == 1) neg += term; else pos += term;
      end
      r = (pos > neg) ? pos - neg : 0;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      v = 64'd1 << 32;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         exp_lut[k] = 32'((v + 64'd32768) >> 16);
         v = (v * r) >> 32;
      end
   endtask

   function automatic longint unsigned neg_exp(longint unsigned x);
      if (x >= (64'd8 << 16)) return 0;
      return exp_lut[(x * TAB_DEPTH) >> 19];
   endfunction

   function automatic bit [15:0] pull_toward(bit [15:0] w, bit [15:0] s,
                                             longint unsigned f);
      if (s >= w) return w + 16'((f * (s - w)) >> 16);
      return w - 16'((f * (w - s)) >> 16);
   endfunction

   // Winner search plus neighborhood update on the shadow map
   function automatic bit [7:0] train_map(bit [15:0] sr, bit [15:0] sg, bit [15:0] sb,
                                          longint unsigned t);
      int unsigned gs, cnt, best, brow, bcol, row, col;
      longint unsigned best_d, sq_err, a, lr, sigma, s2, dr, dc, d2, theta, f;
      longint sdr, sdg, sdb;
      gs = (sh_size < 1) ? 1 : (sh_size > GRID_LIMIT) ? GRID_LIMIT : sh_size;
      cnt = sh_mode ? gs * gs : gs;
      best = 0;
      best_d = '1;
      for (int i = 0; i < cnt; i++) begin
         sdr = longint'(sr) - longint'(map_r[i]);
         sdg = longint'(sg) - longint'(map_g[i]);
         sdb = longint'(sb) - longint'(map_b[i]);
         sq_err = sdr * sdr + sdg * sdg + sdb * sdb;
         if (sq_err < best_d) begin
            best_d = sq_err;
            best = i;
         end
      end
      a = neg_exp((t * sh_decay) >> 16);
      lr = (sh_rate * a) >> 16;
      sigma = (sh_radius * a) >> 8;
      s2 = sigma * sigma;
      brow = sh_mode ? best / gs : best;
      bcol = sh_mode ? best % gs : 0;
      for (int i = 0; i < cnt; i++) begin
         row = sh_mode ? i / gs : i;
         col = sh_mode ? i % gs : 0;
         dr = row > brow ? row - brow : brow - row;
         dc = col > bcol ? col - bcol : bcol - col;
         d2 = dr * dr + dc * dc;
         if (d2 == 0) theta = 65536;
         else if (s2 == 0) theta = 0;        // zero radius: winner only
         else theta = neg_exp((d2 << 47) / s2);
         f = (lr * theta) >> 16;
         if (f != 0) begin
            map_r[i] = pull_toward(map_r[i], sr, f);
            map_g[i] = pull_toward(map_g[i], sg, f);
            map_b[i] = pull_toward(map_b[i], sb, f);
         end
      end
      return best[7:0];
   endfunction

   // Expected word for one accepted item; kind 3 yields nothing
   task automatic predict_word(bit [1:0] kind, bit [7:0] idx, bit [15:0] r, bit [15:0] g,
                               bit [15:0] b, bit [15:0] t);
      som_word_type w;
      w = '0;
      w.kind = kind;
      if (kind == KIND_LOAD) begin
         map_r[idx] = r;
         map_g[idx] = g;
         map_b[idx] = b;
      end else if (kind == KIND_READ) begin
         w.pixel = {8'((map_r[idx] * 255) >> 16), 8'((map_g[idx] * 255) >> 16),
                    8'((map_b[idx] * 255) >> 16)};
      end else if (kind == KIND_TRAIN) begin
         w.winner = train_map(r, g, b, t);
      end
      if (kind != KIND_UNUSED) pending_words.push_back(w);
   endtask

   // Send one item; random idle cycles before it unless in the gap-free stretch
   task automatic send_item(bit [1:0] kind, bit [7:0] idx, bit [15:0] r, bit [15:0] g,
                            bit [15:0] b, bit [15:0] t);
      if (!no_gaps) begin
         start = 1'b0;
         while ($urandom_range(99) < 38) @(negedge clock);
      end
      start = 1'b1;
      req_kind = kind;
      req_node_index = idx;
      req_red_in = r;
      req_green_in = g;
      req_blue_in = b;
      req_step_index = t;
      do @(posedge clock); while (busy);
      predict_word(kind, idx, r, g, b, t);
      item_count++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // Hold off until every expected word is back, then let the block settle
   task automatic drain();
      start = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      drain();
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_GRID_MODE:   sh_mode = value[0];
         CSR_GRID_SIZE:   sh_size = value[4:0];
         CSR_LEARN_RATE:  sh_rate = value[15:0];
         CSR_INIT_RADIUS: sh_radius = value[15:0];
         CSR_DECAY_INV:   sh_decay = value;
         default: ;
      endcase
   endtask

   task automatic set_map_config(bit mode, bit [4:0] size, bit [15:0] rate,
                                 bit [15:0] radius, bit [31:0] decay);
      write_reg(CSR_GRID_MODE, 32'(mode));
      write_reg(CSR_GRID_SIZE, 32'(size));
      write_reg(CSR_LEARN_RATE, 32'(rate));
      write_reg(CSR_INIT_RADIUS, 32'(radius));
      write_reg(CSR_DECAY_INV, decay);
   endtask

   function automatic bit [15:0] rand_step();
      return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
   endfunction

   // Every node gets a defined weight before anything reads it
   task automatic test_load_all_nodes();
      for (int i = 0; i < NODES; i++)
         send_item(KIND_LOAD, 8'(i), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic test_directed();
      send_item(KIND_LOAD, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(KIND_LOAD, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_READ, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0);
      send_item(KIND_READ, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // default config: ordinary training, then decay running past the table
      send_item(KIND_TRAIN, 8'd0, 16'hFFFF, 16'h0000, 16'h8000, 16'd0);
      send_item(KIND_TRAIN, 8'd0, 16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF);
      send_item(KIND_TRAIN, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'd100);
      // unused kind: no word comes back
      send_item(KIND_UNUSED, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_item(KIND_READ, 8'd17, 16'h0, 16'h0, 16'h0, 16'h0);
      // zero radius updates the winner only
      set_map_config(1'b1, 5'd4, 16'hFFFF, 16'd0, 32'd0);
      send_item(KIND_TRAIN, 8'd0, 16'h4000, 16'hC000, 16'h2000, 16'd7);
      send_item(KIND_READ, 8'd5, 16'h0, 16'h0, 16'h0, 16'h0);
      // grid size zero acts as one, oversize acts as the full grid
      set_map_config(1'b0, 5'd0, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(KIND_TRAIN, 8'd0, 16'h1111, 16'h2222, 16'h3333, 16'd0);
      send_item(KIND_TRAIN, 8'd0, 16'h1111, 16'h2222, 16'h3333, 16'd1);
      set_map_config(1'b1, 5'd31, 16'hFFFF, 16'hFFFF, 32'd0);
      send_item(KIND_TRAIN, 8'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd0);
      set_map_config(1'b0, 5'd17, 16'd0, 16'd300, 32'd1000);
      send_item(KIND_TRAIN, 8'd0, 16'h8000, 16'h8000, 16'h8000, 16'd50);
      send_item(KIND_READ, 8'd3, 16'h0, 16'h0, 16'h0, 16'h0);
   endtask

   // Random phases, mostly small grids, one at the full grid size
   task automatic test_random_phases();
      int n_items;
      int roll;
      bit [4:0] size;
      for (int ph = 0; ph < 10; ph++) begin
         size = (ph == 5) ? 5'd16 : 5'($urandom_range(6, 1));
         set_map_config(1'($urandom), size, 16'($urandom),
                        ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(800)),
                        ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(4000000)));
         n_items = (ph == 5) ? 50 : 95;
         for (int i = 0; i < n_items; i++) begin
            no_gaps = (ph == 2);
            roll = $urandom_range(99);
            if (roll < 40)
               send_item(KIND_TRAIN, 8'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), rand_step());
            else if (roll < 68)
               send_item(KIND_LOAD, 8'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
            else if (roll < 97)
               send_item(KIND_READ, 8'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
            else
               send_item(KIND_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
            if (i == 40) drain();   // sender waits out every result once per phase
         end
         no_gaps = 1'b0;
      end
   endtask

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      som_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word winner=%0d pixel=%06h kind=%0d", $time,
                     rsp_winner_index, rsp_pixel_rgb, rsp_ack_kind);
            errors++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_ack_kind !== want.kind) begin
               $display("%0t: ack_kind expected %0d actual %0d", $time, want.kind, rsp_ack_kind);
               errors++;
            end
            if (rsp_winner_index !== want.winner) begin
               $display("%0t: winner_index expected %0d actual %0d", $time, want.winner,
                        rsp_winner_index);
               errors++;
            end
            if (rsp_pixel_rgb !== want.pixel) begin
               $display("%0t: pixel_rgb expected %06h actual %06h", $time, want.pixel,
                        rsp_pixel_rgb);
               errors++;
            end
         end
      end
   end

   // Watchdog: cycles with neither an accepted item nor a result word
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      build_exp_lut();
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_load_all_nodes();
      test_directed();
      test_random_phases();
      drain();
      if (errors == 0 && pending_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[som_color_training_step.f]
rtl/som_pkg.sv
rtl/som_ram.sv
rtl/som_div.sv
rtl/som_dist.sv
rtl/som_color_training_step.sv
tb/sv/testbench.sv
